FILE: rtl/pbart_pkg.sv
package pbart_pkg;

    // Field widths of the command and result items.
    localparam int ACTION_W  = 2;
    localparam int COUNT_W   = 11;
    localparam int ADDR_W    = 23;
    localparam int STATUS_W  = 2;
    localparam int START_W   = 22;
    localparam int USED_W    = 11;
    localparam int REGIONS_W = 9;
    localparam int FREE_N_W  = 9;
    localparam int RUN_W     = 11;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_STATS = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd2;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [COUNT_W-1:0]  page_count;
        logic [ADDR_W-1:0]   byte_address;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [START_W-1:0]   start_offset;
        logic [USED_W-1:0]    pages_in_use;
        logic [REGIONS_W-1:0] regions_used;
        logic [FREE_N_W-1:0]  free_region_count;
        logic [RUN_W-1:0]     largest_free_run;
    } t_result;

endpackage

FILE: rtl/pbart_alu.sv
// Shared arithmetic unit: one add/subtract with a limit compare, and one
// multiply of a page number by the page size.
module pbart_alu import pbart_pkg::*; #(
    parameter int SW         = 12,
    parameter int PAGE_W     = 11,
    parameter int AW         = 24,
    parameter int PAGE_BYTES = 4096
) (
    input  t_alu_op           i_op,
    input  logic [SW-1:0]     i_a,
    input  logic [SW-1:0]     i_b,
    input  logic [SW-1:0]     i_lim,
    input  logic [PAGE_W-1:0] i_mul_page,
    output logic [SW-1:0]     o_res,
    output logic              o_borrow,
    output logic              o_gt,
    output logic [AW-1:0]     o_product
);

    logic [SW:0] wide;

    always_comb begin
        case (i_op)
            ALU_SUB: wide = {1'b0, i_a} - {1'b0, i_b};
            default: wide = {1'b0, i_a} + {1'b0, i_b};
        endcase
        o_res    = wide[SW-1:0];
        o_borrow = (i_op == ALU_SUB) && wide[SW];
        o_gt     = wide[SW-1:0] > i_lim;
    end

    assign o_product = AW'(i_mul_page) * AW'(PAGE_BYTES);

endmodule

FILE: rtl/page_bump_allocator_region_table_top.sv
// Page allocator with a region table. A command is transferred when start is
// high and busy is low; its single result appears on o_result for exactly one
// cycle, flagged by o_done, and cannot be held off. Allocate writes the table
// entry in S_ALLOC and updates the used count in S_ALLOC_UPD before it answers;
// a refused allocate answers from S_ALLOC. Free and statistics walk the appended
// table entries one per cycle through the table memory's single read port and
// answer when the walk ends (free stops early at the matching entry); a free
// whose address lies outside the pool, and an unused action code, answer in the
// next cycle. busy drops in the cycle o_done is shown, so a new command may be
// transferred while the previous result is on the ports. Freed pages are never
// handed out again: the bump offset only rises.
module page_bump_allocator_region_table_top import pbart_pkg::*; #(
    parameter int POOL_PAGES    = 1024,
    parameter int TABLE_ENTRIES = 256,
    parameter int PAGE_BYTES    = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    // Page numbers and page counts up to POOL_PAGES inclusive.
    localparam int PAGE_W = $clog2(POOL_PAGES + 1);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    // Adder width covers a page number plus a requested count without overflow.
    localparam int SW     = ((PAGE_W > COUNT_W) ? PAGE_W : COUNT_W) + 1;
    // Byte address width covers the pool size and the command's address field.
    localparam int AW     = (PAGE_W + PB_W > ADDR_W) ? (PAGE_W + PB_W) : ADDR_W;
    localparam longint unsigned POOL_BYTES_L =
        longint'(POOL_PAGES) * longint'(PAGE_BYTES);
    localparam logic [AW-1:0] POOL_BYTES = AW'(POOL_BYTES_L);

    typedef struct packed {
        logic              live;
        logic [PAGE_W-1:0] start;
        logic [PAGE_W-1:0] pages;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE      = 5'b00001,
        S_ALLOC     = 5'b00010,
        S_ALLOC_UPD = 5'b00100,
        S_SCAN      = 5'b01000,
        S_FREE_UPD  = 5'b10000
    } t_state;

    // Region table: one write port, one registered read port.
    t_entry r_table [TABLE_ENTRIES];
    t_entry r_rd;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_entry, n_entry;
    logic [PAGE_W-1:0] r_used, n_used;
    logic [PAGE_W-1:0] r_bump, n_bump;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_free_n, n_free_n;
    logic [PAGE_W-1:0] r_run, n_run;
    logic [PAGE_W-1:0] r_best, n_best;
    logic [START_W-1:0] r_start, n_start;
    logic [STATUS_W-1:0] r_status, n_status;
    logic              r_done, n_done;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    t_entry            mem_wd;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_ra;

    t_alu_op           alu_op;
    logic [SW-1:0]     alu_a;
    logic [SW-1:0]     alu_b;
    logic [SW-1:0]     alu_lim;
    logic [SW-1:0]     alu_res;
    logic              alu_borrow;
    logic              alu_gt;
    logic [PAGE_W-1:0] mul_page;
    logic [AW-1:0]     mul_product;

    logic              refuse;
    logic              hit;

    pbart_alu #(
        .SW         (SW),
        .PAGE_W     (PAGE_W),
        .AW         (AW),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_alu (
        .i_op       (alu_op),
        .i_a        (alu_a),
        .i_b        (alu_b),
        .i_lim      (alu_lim),
        .i_mul_page (mul_page),
        .o_res      (alu_res),
        .o_borrow   (alu_borrow),
        .o_gt       (alu_gt),
        .o_product  (mul_product)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    always_comb begin
        o_result.status            = r_status;
        o_result.start_offset      = r_start;
        o_result.pages_in_use      = USED_W'(r_used);
        o_result.regions_used      = REGIONS_W'(r_entry);
        o_result.free_region_count = FREE_N_W'(r_free_n);
        o_result.largest_free_run  = RUN_W'(r_best);
    end

    // The multiplier converts the bump offset to a byte address while
    // allocating, and a stored start page to a byte address while searching.
    assign mul_page = (r_state == S_ALLOC) ? r_bump : r_rd.start;

    assign refuse = (r_cmd.page_count == '0) ||
                    (r_entry >= CNT_W'(TABLE_ENTRIES)) || alu_gt;
    assign hit    = r_rd.live && (mul_product == AW'(r_cmd.byte_address));

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_entry  = r_entry;
        n_used   = r_used;
        n_bump   = r_bump;
        n_issue  = r_issue;
        n_rd_vld = 1'b0;
        n_rd_idx = r_rd_idx;
        n_free_n = r_free_n;
        n_run    = r_run;
        n_best   = r_best;
        n_start  = r_start;
        n_status = r_status;
        n_done   = 1'b0;

        mem_we = 1'b0;
        mem_wa = r_entry[IDX_W-1:0];
        mem_wd = r_rd;
        mem_re = 1'b0;
        mem_ra = r_issue[IDX_W-1:0];

        alu_op  = ALU_ADD;
        alu_a   = SW'(r_run);
        alu_b   = SW'(r_rd.pages);
        alu_lim = SW'(r_best);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_cmd;
                    n_start  = '0;
                    n_free_n = '0;
                    n_run    = '0;
                    n_best   = '0;
                    n_issue  = '0;
                    case (i_cmd.action)
                        ACT_ALLOC: n_state = S_ALLOC;
                        ACT_FREE: begin
                            if (AW'(i_cmd.byte_address) < POOL_BYTES) begin
                                n_state = S_SCAN;
                            end else begin
                                n_status = ST_MISS;
                                n_done   = 1'b1;
                            end
                        end
                        ACT_STATS: n_state = S_SCAN;
                        default: begin
                            n_status = ST_OK;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                // Bump offset plus request, checked against the pool size.
                alu_a   = SW'(r_bump);
                alu_b   = SW'(r_cmd.page_count);
                alu_lim = SW'(POOL_PAGES);
                if (refuse) begin
                    n_status = ST_REFUSED;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    mem_we       = 1'b1;
                    mem_wa       = r_entry[IDX_W-1:0];
                    mem_wd.live  = 1'b1;
                    mem_wd.start = r_bump;
                    mem_wd.pages = PAGE_W'(r_cmd.page_count);
                    n_start      = START_W'(mul_product);
                    n_bump       = PAGE_W'(alu_res);
                    n_entry      = r_entry + 1'b1;
                    n_state      = S_ALLOC_UPD;
                end
            end

            S_ALLOC_UPD: begin
                alu_a    = SW'(r_used);
                alu_b    = SW'(r_cmd.page_count);
                n_used   = PAGE_W'(alu_res);
                n_status = ST_OK;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end

            S_SCAN: begin
                // Reads are issued one entry per cycle; the data of the entry
                // issued in the previous cycle is examined here.
                if (r_issue < r_entry) begin
                    mem_re   = 1'b1;
                    n_issue  = r_issue + 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_issue[IDX_W-1:0];
                end
                if (r_rd_vld) begin
                    if (r_cmd.action == ACT_FREE) begin
                        if (hit) begin
                            mem_we      = 1'b1;
                            mem_wa      = r_rd_idx;
                            mem_wd.live = 1'b0;
                            n_rd_vld    = 1'b0;
                            n_state     = S_FREE_UPD;
                        end
                    end else begin
                        if (!r_rd.live) begin
                            n_free_n = r_free_n + 1'b1;
                            n_run    = PAGE_W'(alu_res);
                            if (alu_gt) begin
                                n_best = PAGE_W'(alu_res);
                            end
                        end else begin
                            n_run = '0;
                        end
                    end
                end else if (r_issue >= r_entry) begin
                    // Walk finished without a match, or statistics complete.
                    n_status = (r_cmd.action == ACT_FREE) ? ST_MISS : ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_FREE_UPD: begin
                // Used count drops by the given count, saturating at zero.
                alu_op   = ALU_SUB;
                alu_a    = SW'(r_used);
                alu_b    = SW'(r_cmd.page_count);
                n_used   = alu_borrow ? '0 : PAGE_W'(alu_res);
                n_status = ST_OK;
                n_done   = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_table[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_rd_idx <= n_rd_idx;
        r_start  <= n_start;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_entry  <= '0;
            r_used   <= '0;
            r_bump   <= '0;
            r_issue  <= '0;
            r_rd_vld <= 1'b0;
            r_free_n <= '0;
            r_run    <= '0;
            r_best   <= '0;
            r_status <= ST_OK;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_entry  <= n_entry;
            r_used   <= n_used;
            r_bump   <= n_bump;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_free_n <= n_free_n;
            r_run    <= n_run;
            r_best   <= n_best;
            r_status <= n_status;
            r_done   <= n_done;
        end
    end

    // A result is only ever shown once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while the sequencer is busy");

    // Every transfer either starts work or answers in the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("transferred command neither started nor answered");

    // Pages in use never exceed the pages ever handed out.
    a_used_le_bump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_bump)
        else $error("used page count exceeds bump offset");

    // The bump offset stays within the pool.
    a_bump_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bump <= PAGE_W'(POOL_PAGES))
        else $error("bump offset beyond pool");

    // The table never grows past its capacity.
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry <= CNT_W'(TABLE_ENTRIES))
        else $error("region table overfilled");

endmodule

FILE: tb/tb_page_bump_allocator_region_table_top.sv
`timescale 1ns / 100ps

// Testbench for the page allocator with its region table.
//
// One clocked process does all the driving and checking. At each rising edge
// it looks at the values from before the edge: a result strobe is matched
// against the oldest expected result, and a command transfer (start high,
// busy low) runs the predictor below and queues its answer. Then it picks
// what to drive for the next cycle. start gets exactly one nonblocking
// assignment per edge and i_cmd at most one, so a start that stays high for the next
// command is never dropped and raised in the same step.
//
// The stimulus is a short directed table followed by random commands. The
// random commands are built from the predicted table contents at the moment
// they are issued, so that most frees name a region that really exists.
// Since reset is applied only once, the pool and the table fill only once per
// run; allocations are kept small so that the table fills before the pool, and
// the seed decides whether the run ends by filling the pool exactly.
module tb_page_bump_allocator_region_table_top;
    import pbart_pkg::*;

    localparam int POOL_PAGES    = 1024;
    localparam int TABLE_ENTRIES = 256;
    localparam int PAGE_BYTES    = 4096;
    localparam int POOL_BYTES    = POOL_PAGES * PAGE_BYTES;

    // The one action code that the package leaves unnamed.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1250;
    localparam int TOTAL_ITEMS    = RANDOM_ITEMS + 24;
    localparam int REPORT_LIMIT   = 10;
    // A walk over a full table reads all TABLE_ENTRIES entries.
    localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 40;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    page_bump_allocator_region_table_top #(
        .POOL_PAGES   (POOL_PAGES),
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .PAGE_BYTES   (PAGE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Predicted allocator state. All of it starts at zero, which is also
    // the state right after reset.
    // ------------------------------------------------------------------
    bit [9:0]           tbl_start_page [TABLE_ENTRIES];
    bit [COUNT_W-1:0]   tbl_pages      [TABLE_ENTRIES];
    bit                 tbl_live       [TABLE_ENTRIES];
    bit [REGIONS_W-1:0] tbl_count;
    bit [USED_W-1:0]    pages_used;
    bit [10:0]          bump_next;

    // Applies one command to the predicted state and returns its answer.
    function automatic t_result allocator_step(input t_cmd c);
        t_result r;
        int      i;
        int      run;
        int      best;
        int      n_free;
        r      = '0;
        run    = 0;
        best   = 0;
        n_free = 0;
        case (c.action)
            ACT_ALLOC: begin
                if (c.page_count == 0 || int'(tbl_count) >= TABLE_ENTRIES ||
                    int'(bump_next) + int'(c.page_count) > POOL_PAGES) begin
                    r.status = ST_REFUSED;
                end else begin
                    tbl_start_page[tbl_count] = bump_next[9:0];
                    tbl_pages[tbl_count]      = c.page_count;
                    tbl_live[tbl_count]       = 1'b1;
                    tbl_count                 = tbl_count + 1'b1;
                    r.status       = ST_OK;
                    r.start_offset = START_W'(int'(bump_next) * PAGE_BYTES);
                    bump_next      = bump_next + c.page_count;
                    pages_used     = pages_used + c.page_count;
                end
            end
            ACT_FREE: begin
                r.status = ST_MISS;
                if (int'(c.byte_address) < POOL_BYTES) begin
                    for (i = 0; i < int'(tbl_count); i++) begin
                        if (tbl_live[i] &&
                            int'(tbl_start_page[i]) * PAGE_BYTES == int'(c.byte_address)) begin
                            tbl_live[i] = 1'b0;
                            pages_used  = (pages_used > c.page_count) ?
                                          pages_used - c.page_count : '0;
                            r.status    = ST_OK;
                            break;
                        end
                    end
                end
            end
            ACT_STATS: begin
                // A run of freed entries that reaches the last entry counts.
                for (i = 0; i < int'(tbl_count); i++) begin
                    if (!tbl_live[i]) begin
                        n_free++;
                        run += int'(tbl_pages[i]);
                        if (run > best) best = run;
                    end else begin
                        run = 0;
                    end
                end
            end
            default: begin
                r.status = ST_OK;
            end
        endcase
        r.pages_in_use      = pages_used;
        r.regions_used      = tbl_count;
        r.free_region_count = FREE_N_W'(n_free);
        r.largest_free_run  = RUN_W'(best);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result answer;
    } stim_row_t;

    stim_row_t directed_rows[$];
    bit        fill_pool_exactly;

    function automatic t_cmd mk_cmd(input logic [ACTION_W-1:0] act, input int count,
                                    input int addr);
        t_cmd c;
        c.action       = act;
        c.page_count   = COUNT_W'(count);
        c.byte_address = ADDR_W'(addr);
        return c;
    endfunction

    function automatic t_result mk_res(input logic [STATUS_W-1:0] st, input int offs,
                                       input int used, input int regions);
        t_result r;
        r                   = '0;
        r.status            = st;
        r.start_offset      = START_W'(offs);
        r.pages_in_use      = USED_W'(used);
        r.regions_used      = REGIONS_W'(regions);
        return r;
    endfunction

    task automatic add_row(input t_cmd c, input bit typed, input t_result answer);
        stim_row_t row;
        row.cmd    = c;
        row.typed  = typed;
        row.answer = answer;
        directed_rows.push_back(row);
    endtask

    // Random command drawn against the predicted table. Frees mostly name
    // the start of a region that is still live; the rest is noise.
    function automatic t_cmd random_command();
        t_cmd c;
        int   k;
        int   remain;
        int   idx;
        int   tries;
        remain         = POOL_PAGES - int'(bump_next);
        c.page_count   = COUNT_W'($urandom_range(0, 2047));
        c.byte_address = ADDR_W'($urandom_range(0, 8388607));
        k = $urandom_range(0, 99);
        if (k < 40) begin
            c.action = ACT_ALLOC;
            k = $urandom_range(0, 99);
            if (fill_pool_exactly && int'(tbl_count) >= TABLE_ENTRIES - 6 &&
                remain > 0 && k < 40) begin
                // One page past the end, or exactly up to the end.
                c.page_count = COUNT_W'((k < 20) ? remain + 1 : remain);
            end else if (k < 5) begin
                c.page_count = '0;
            end else if (k < 70) begin
                c.page_count = COUNT_W'($urandom_range(1, 2));
            end else if (k < 90) begin
                c.page_count = COUNT_W'($urandom_range(1, 8));
            end else begin
                c.page_count = COUNT_W'($urandom_range(remain + 1, 2047));
            end
        end else if (k < 75) begin
            c.action = ACT_FREE;
            k = $urandom_range(0, 99);
            if (k < 80 && tbl_count != 0) begin
                idx = $urandom_range(0, int'(tbl_count) - 1);
                for (tries = 0; tries < 8 && !tbl_live[idx]; tries++) begin
                    idx = $urandom_range(0, int'(tbl_count) - 1);
                end
                c.byte_address = ADDR_W'(int'(tbl_start_page[idx]) * PAGE_BYTES);
                k = $urandom_range(0, 99);
                if (k < 70) begin
                    c.page_count = tbl_pages[idx];
                end else if (k < 80) begin
                    c.page_count = '0;
                end
            end else if (k < 90) begin
                c.byte_address = ADDR_W'($urandom_range(0, POOL_BYTES - 1));
            end else begin
                c.byte_address = ADDR_W'($urandom_range(POOL_BYTES, 8388607));
            end
        end else if (k < 93) begin
            c.action = ACT_STATS;
        end else begin
            c.action = ACT_UNUSED;
        end
        return c;
    endfunction

    initial begin
        fill_pool_exactly = $urandom_range(0, 1);
        // Empty table: statistics, frees that find nothing, refused allocates, unused action codes.
        add_row(mk_cmd(ACT_STATS, 0, 0), 1'b1, mk_res(ST_OK, 0, 0, 0));
        add_row(mk_cmd(ACT_FREE, 0, 0), 1'b1, mk_res(ST_MISS, 0, 0, 0));
        add_row(mk_cmd(ACT_FREE, 2047, 8388607), 1'b1, mk_res(ST_MISS, 0, 0, 0));
        add_row(mk_cmd(ACT_ALLOC, 0, 0), 1'b1, mk_res(ST_REFUSED, 0, 0, 0));
        add_row(mk_cmd(ACT_ALLOC, 2047, 8388607), 1'b1, mk_res(ST_REFUSED, 0, 0, 0));
        add_row(mk_cmd(ACT_ALLOC, POOL_PAGES + 1, 0), 1'b1, mk_res(ST_REFUSED, 0, 0, 0));
        add_row(mk_cmd(ACT_UNUSED, 2047, 8388607), 1'b1, mk_res(ST_OK, 0, 0, 0));
        add_row(mk_cmd(ACT_UNUSED, 0, 0), 1'b1, mk_res(ST_OK, 0, 0, 0));
        // First regions: pages 0, 1..3, then 4..5.
        add_row(mk_cmd(ACT_ALLOC, 1, 8388607), 1'b1, mk_res(ST_OK, 0, 1, 1));
        add_row(mk_cmd(ACT_ALLOC, 3, 0), 1'b1, mk_res(ST_OK, PAGE_BYTES, 4, 2));
        add_row(mk_cmd(ACT_ALLOC, 2, 0), 1'b0, '0);
        // Free the middle region, then try it again and off by one byte.
        add_row(mk_cmd(ACT_FREE, 3, PAGE_BYTES), 1'b0, '0);
        add_row(mk_cmd(ACT_STATS, 0, 0), 1'b0, '0);
        add_row(mk_cmd(ACT_FREE, 3, PAGE_BYTES), 1'b0, '0);
        add_row(mk_cmd(ACT_FREE, 1, PAGE_BYTES + 1), 1'b0, '0);
        // A free count above the pages in use saturates at zero.
        add_row(mk_cmd(ACT_FREE, 2047, 0), 1'b0, '0);
        add_row(mk_cmd(ACT_STATS, 0, 0), 1'b0, '0);
        // Freeing the last region makes the run reach the end of the table.
        add_row(mk_cmd(ACT_FREE, 2, 4 * PAGE_BYTES), 1'b0, '0);
        add_row(mk_cmd(ACT_STATS, 0, 0), 1'b0, '0);
        // Just outside and just inside the pool boundary.
        add_row(mk_cmd(ACT_FREE, 0, POOL_BYTES), 1'b0, '0);
        add_row(mk_cmd(ACT_FREE, 0, POOL_BYTES - 1), 1'b0, '0);
        add_row(mk_cmd(ACT_ALLOC, 5, 0), 1'b0, '0);
        add_row(mk_cmd(ACT_STATS, 0, 0), 1'b0, '0);
    end

    // ------------------------------------------------------------------
    // Driving and checking.
    // ------------------------------------------------------------------
    t_result expected_results[$];
    int      error_count  = 0;
    int      report_count = 0;
    bit      stim_done    = 1'b0;

    task automatic compare_result(input t_result want, input t_result got);
        bit bad;
        bad = (got.status            !== want.status)            ||
              (got.start_offset      !== want.start_offset)      ||
              (got.pages_in_use      !== want.pages_in_use)      ||
              (got.regions_used      !== want.regions_used)      ||
              (got.free_region_count !== want.free_region_count) ||
              (got.largest_free_run  !== want.largest_free_run);
        if (bad) begin
            error_count++;
            if (report_count < REPORT_LIMIT) begin
                report_count++;
                $display("%0t result mismatch: want st=%0d offs=%0h used=%0d regs=%0d",
                         $realtime, want.status, want.start_offset, want.pages_in_use,
                         want.regions_used);
                $display("    free=%0d run=%0d | got st=%0d offs=%0h used=%0d regs=%0d",
                         want.free_region_count, want.largest_free_run, got.status,
                         got.start_offset, got.pages_in_use, got.regions_used);
                $display("    free=%0d run=%0d", got.free_region_count,
                         got.largest_free_run);
            end
        end
    endtask

    int      row_idx      = 0;
    int      random_sent  = 0;
    int      issued       = 0;
    int      last_phase   = 0;
    bit      drain_first  = 1'b0;
    bit      cur_typed    = 1'b0;
    t_result cur_answer   = '0;

    always @(posedge i_clk) begin : drive_and_check
        t_result predicted;
        logic    next_start;
        t_cmd    next_cmd;
        int      phase;
        int      idle_pct;
        bit      have_cmd;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // A result is shown for one cycle only and must be taken now.
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (report_count < REPORT_LIMIT) begin
                        report_count++;
                        $display("%0t result with no command waiting for it", $realtime);
                    end
                end else begin
                    compare_result(expected_results.pop_front(), o_result);
                end
            end

            next_start = start;
            if (start && !busy) begin
                // Transfer of the command on i_cmd.
                predicted = allocator_step(i_cmd);
                expected_results.push_back(cur_typed ? cur_answer : predicted);
                next_start = 1'b0;
            end

            if (!next_start && !stim_done) begin
                // Sender idling: light, then heavy, then none.
                phase = issued * 3 / TOTAL_ITEMS;
                if (phase > 2) phase = 2;
                idle_pct = (phase == 0) ? 16 : (phase == 1) ? 56 : 0;
                if (phase != last_phase) begin
                    last_phase  = phase;
                    drain_first = 1'b1;
                end
                if (drain_first && expected_results.size() != 0) begin
                    // Hold off until every outstanding result has come back.
                end else if ($urandom_range(0, 99) < idle_pct) begin
                    // Idle cycle.
                end else begin
                    drain_first = 1'b0;
                    have_cmd    = 1'b1;
                    if (row_idx < directed_rows.size()) begin
                        next_cmd   = directed_rows[row_idx].cmd;
                        cur_typed  = directed_rows[row_idx].typed;
                        cur_answer = directed_rows[row_idx].answer;
                        row_idx++;
                    end else if (random_sent < RANDOM_ITEMS) begin
                        next_cmd  = random_command();
                        cur_typed = 1'b0;
                        random_sent++;
                    end else begin
                        have_cmd  = 1'b0;
                        stim_done = 1'b1;
                    end
                    if (have_cmd) begin
                        i_cmd     <= next_cmd;
                        next_start = 1'b1;
                        issued++;
                        if (issued % 97 == 0 || $urandom_range(0, 199) == 0) begin
                            drain_first = 1'b1;
                        end
                    end
                end
            end
            start <= next_start;
        end
    end

    // ------------------------------------------------------------------
    // End of run. Polled on the falling edge, away from the process above.
    // ------------------------------------------------------------------
    initial begin
        while (!(stim_done && expected_results.size() == 0)) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
